@@ sv/mcfed_pkg.sv @@
package mcfed_pkg;

  // Payload widths of the item and result channels.
  localparam int KIND_W    = 2;
  localparam int CURRENT_W = 12;
  localparam int SPEED_W   = 16;
  localparam int TICKS_W   = 32;
  localparam int FILT_W    = 12;
  localparam int CAUSE_W   = 2;

  // Configuration port.
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 5;
  localparam int REG_W   = 3;

  localparam int CUR_CNT_W = 16;
  localparam int SPD_CNT_W = 15;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRIME  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE        = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_OVERCURRENT = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_SPEED_STALL = 2'd2;

  localparam logic [REG_W-1:0] REG_CURRENT_THRESHOLD = 3'd0;
  localparam logic [REG_W-1:0] REG_CURRENT_LIMIT     = 3'd1;
  localparam logic [REG_W-1:0] REG_SPEED_THRESHOLD   = 3'd2;
  localparam logic [REG_W-1:0] REG_SPEED_LIMIT       = 3'd3;
  localparam logic [REG_W-1:0] REG_MIN_RUN_TICKS     = 3'd4;

endpackage

@@ sv/mcfed_if.sv @@
interface mcfed_in_if;
  import mcfed_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [KIND_W-1:0]           kind;
  logic [CURRENT_W-1:0]        current_mv;
  logic signed [SPEED_W-1:0]   speed_counts;
  logic [TICKS_W-1:0]          run_ticks;

  modport source (output valid, kind, current_mv, speed_counts, run_ticks, input ready);
  modport sink (input valid, kind, current_mv, speed_counts, run_ticks, output ready);
endinterface

interface mcfed_out_if;
  import mcfed_pkg::*;

  logic               valid;
  logic               ready;
  logic [FILT_W-1:0]  filtered_mv;
  logic               end_reached;
  logic [CAUSE_W-1:0] end_cause;

  modport source (output valid, filtered_mv, end_reached, end_cause, input ready);
  modport sink (input valid, filtered_mv, end_reached, end_cause, output ready);
endinterface

@@ sv/motor_current_filter_end_detector.sv @@
// Motor current moving-average filter with end-of-travel detection.
//
// Items enter on the item channel and each produces exactly one transaction on
// the result channel. A sample item replaces the oldest ring entry and updates
// the mean; a prime item loads every ring entry with one sample; a check item
// runs the over-current and slow-speed detectors. Thresholds and limits are
// written through the APB port; the user must do so only while the block is
// idle, as the block itself does not enforce it.
//
// The block holds one item at a time; item.ready is high only while the
// sequencer is idle. Each accepted item steps the sequencer through:
//   sample: ST_RMW, then ST_DIV for the reciprocal multiply that divides by
//           the ring depth unless RING_DEPTH is a power of two, then ST_DONE
//   prime:  ST_PRIME, one ring entry written per cycle, then ST_DONE
//   check:  ST_CUR, then ST_SPD unless the current test tripped, then ST_DONE
//   unused kind: ST_DONE
// The ring memory has a single write port. The next item can be accepted in
// the cycle after a result is raised. A result waits in an output register
// while the next item is accepted and worked on; a stalled receiver holds the
// sequencer only in its final step.
// Reset restores the register defaults and clears the counters; per-entry
// valid bits make the whole ring read as zero at once, so no clearing pass.
module motor_current_filter_end_detector #(
  parameter int RING_DEPTH  = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  mcfed_in_if.sink                      item,
  mcfed_out_if.source                   result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcfed_pkg::PADDR_W-1:0] paddr,
  input  logic [mcfed_pkg::PDATA_W-1:0] pwdata,
  output logic [mcfed_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import mcfed_pkg::*;

  localparam int  DW      = $clog2(RING_DEPTH);
  localparam int  SUM_W   = SAMPLE_BITS + DW;
  localparam bit  IS_POW2 = ((1 << DW) == RING_DEPTH);
  localparam int  FC_W    = (SAMPLE_BITS > CURRENT_W) ? SAMPLE_BITS : CURRENT_W;
  localparam int  MAX_SUM = ((1 << SAMPLE_BITS) - 1) * RING_DEPTH;

  // Rounded-up reciprocal of the depth; exact for every sum that fits SUM_W bits.
  localparam int     RECIP_SH = SUM_W + DW;
  localparam longint RECIP    = ((longint'(1) << RECIP_SH) + longint'(RING_DEPTH) - 1)
                                / longint'(RING_DEPTH);
  localparam logic [SUM_W:0] RECIP_M = (SUM_W + 1)'(RECIP);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_DIV,
    ST_PRIME,
    ST_CUR,
    ST_SPD,
    ST_DONE
  } state_t;

  // Configuration registers.
  logic [CURRENT_W-1:0] current_threshold_mv;
  logic [CUR_CNT_W-1:0] current_count_limit;
  logic [SPEED_W-1:0]   speed_threshold;
  logic [SPD_CNT_W-1:0] speed_count_limit;
  logic [TICKS_W-1:0]   min_run_ticks;

  logic             cfg_write;
  logic [REG_W-1:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      current_threshold_mv <= '1;
      current_count_limit  <= CUR_CNT_W'(10);
      speed_threshold      <= SPEED_W'(5);
      speed_count_limit    <= SPD_CNT_W'(10);
      min_run_ticks        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CURRENT_THRESHOLD: current_threshold_mv <= pwdata[CURRENT_W-1:0];
        REG_CURRENT_LIMIT:     current_count_limit  <= pwdata[CUR_CNT_W-1:0];
        REG_SPEED_THRESHOLD:   speed_threshold      <= pwdata[SPEED_W-1:0];
        REG_SPEED_LIMIT:       speed_count_limit    <= pwdata[SPD_CNT_W-1:0];
        REG_MIN_RUN_TICKS:     min_run_ticks        <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_CURRENT_THRESHOLD: prdata = PDATA_W'(current_threshold_mv);
      REG_CURRENT_LIMIT:     prdata = PDATA_W'(current_count_limit);
      REG_SPEED_THRESHOLD:   prdata = PDATA_W'(speed_threshold);
      REG_SPEED_LIMIT:       prdata = PDATA_W'(speed_count_limit);
      REG_MIN_RUN_TICKS:     prdata = PDATA_W'(min_run_ticks);
      default:               prdata = '0;
    endcase
  end

  // Sequencer state and datapath registers.
  state_t                  state;
  logic [SAMPLE_BITS-1:0]  sample;
  logic [SPEED_W-1:0]      speed_raw;
  logic [TICKS_W-1:0]      ticks;
  logic [SUM_W-1:0]        ring_sum;
  logic [DW-1:0]           write_index;
  logic [DW-1:0]           prime_addr;
  logic [SAMPLE_BITS-1:0]  filtered_value;
  logic [CUR_CNT_W-1:0]    over_current_count;
  logic [SPD_CNT_W-1:0]    slow_speed_count;
  logic [RING_DEPTH-1:0]   ring_valid;
  logic                    res_end;
  logic [CAUSE_W-1:0]      res_cause;
  logic [SUM_W-1:0]        div_num;

  // Ring memory.
  logic [SAMPLE_BITS-1:0]  ring_mem [RING_DEPTH];
  logic [SAMPLE_BITS-1:0]  ring_rdata;
  logic                    ring_rvalid;
  logic                    mem_we;
  logic [DW-1:0]           mem_waddr;

  assign mem_we    = (state == ST_RMW) || (state == ST_PRIME);
  assign mem_waddr = (state == ST_PRIME) ? prime_addr : write_index;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= sample;
    end
    ring_rdata <= ring_mem[write_index];
  end

  // Datapath terms.
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       new_sum;
  logic [SUM_W-1:0]       prime_sum;
  logic [DW-1:0]          index_next;
  logic [2*SUM_W:0]       div_prod;
  logic                   current_hit;
  logic [CUR_CNT_W-1:0]   over_inc;
  logic [SPEED_W-1:0]     speed_mag;
  logic                   speed_slow;
  logic [SPD_CNT_W-1:0]   slow_inc;
  logic                   out_free;

  always_comb begin
    old_sample   = ring_rvalid ? ring_rdata : '0;
    new_sum      = ring_sum - SUM_W'(old_sample) + SUM_W'(sample);
    prime_sum    = SUM_W'(sample) * SUM_W'(RING_DEPTH);
    index_next   = (write_index == DW'(RING_DEPTH - 1)) ? '0 : write_index + DW'(1);
    div_prod     = {{(SUM_W + 1){1'b0}}, div_num} * {{SUM_W{1'b0}}, RECIP_M};
    current_hit  = (FC_W'(filtered_value) >= FC_W'(current_threshold_mv));
    over_inc     = (over_current_count == '1) ? over_current_count
                                              : over_current_count + CUR_CNT_W'(1);
    speed_mag    = speed_raw[SPEED_W-1] ? SPEED_W'(SPEED_W'(0) - speed_raw) : speed_raw;
    speed_slow   = (speed_mag < speed_threshold) && (ticks > min_run_ticks);
    slow_inc     = (slow_speed_count == '1) ? slow_speed_count
                                            : slow_speed_count + SPD_CNT_W'(1);
    out_free     = !result.valid || result.ready;
  end

  assign item.ready = (state == ST_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      ring_sum           <= '0;
      write_index        <= '0;
      filtered_value     <= '0;
      over_current_count <= '0;
      slow_speed_count   <= '0;
      ring_valid         <= '0;
      result.valid       <= 1'b0;
    end else begin
      ring_rvalid <= ring_valid[write_index];
      if (result.valid && result.ready && (state != ST_DONE)) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            sample     <= SAMPLE_BITS'(item.current_mv);
            speed_raw  <= item.speed_counts;
            ticks      <= item.run_ticks;
            res_end    <= 1'b0;
            res_cause  <= CAUSE_NONE;
            prime_addr <= '0;
            unique case (item.kind)
              KIND_SAMPLE: state <= ST_RMW;
              KIND_PRIME:  state <= ST_PRIME;
              KIND_CHECK:  state <= ST_CUR;
              default:     state <= ST_DONE;
            endcase
          end
        end
        ST_RMW: begin
          ring_valid[write_index] <= 1'b1;
          ring_sum    <= new_sum;
          write_index <= index_next;
          if (IS_POW2) begin
            filtered_value <= new_sum[SUM_W-1 -: SAMPLE_BITS];
            state          <= ST_DONE;
          end else begin
            div_num <= new_sum;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Divide by the ring depth with the reciprocal multiply.
          filtered_value <= div_prod[RECIP_SH +: SAMPLE_BITS];
          state          <= ST_DONE;
        end
        ST_PRIME: begin
          ring_valid[prime_addr] <= 1'b1;
          prime_addr <= prime_addr + DW'(1);
          if (prime_addr == DW'(RING_DEPTH - 1)) begin
            ring_sum <= prime_sum;
            state    <= ST_DONE;
          end
        end
        ST_CUR: begin
          if (current_hit) begin
            over_current_count <= over_inc;
            if (over_inc > current_count_limit) begin
              res_end   <= 1'b1;
              res_cause <= CAUSE_OVERCURRENT;
              state     <= ST_DONE;
            end else begin
              state <= ST_SPD;
            end
          end else begin
            if (over_current_count != '0) begin
              over_current_count <= over_current_count - CUR_CNT_W'(1);
            end
            state <= ST_SPD;
          end
        end
        ST_SPD: begin
          // The slow counter decays only down to one.
          if (speed_slow) begin
            slow_speed_count <= slow_inc;
            if (slow_inc >= speed_count_limit) begin
              res_end   <= 1'b1;
              res_cause <= CAUSE_SPEED_STALL;
            end
          end else if (slow_speed_count > SPD_CNT_W'(1)) begin
            slow_speed_count <= slow_speed_count - SPD_CNT_W'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            result.valid       <= 1'b1;
            result.filtered_mv <= FILT_W'(filtered_value);
            result.end_reached <= res_end;
            result.end_cause   <= res_cause;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // An end flag always comes with a cause, and no cause without it.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.end_reached == (result.end_cause != CAUSE_NONE)))
    else $error("end_reached and end_cause disagree");

  // The slow-speed counter never decays back to zero once it has counted.
  assert property (@(posedge clk) disable iff (rst)
    (slow_speed_count != '0) |=> (slow_speed_count != '0))
    else $error("slow speed counter decayed to zero");

  // The running sum never exceeds a full ring of maximum samples.
  assert property (@(posedge clk) disable iff (rst)
    ring_sum <= SUM_W'(MAX_SUM))
    else $error("ring sum out of range");

  // The over-current counter moves by at most one per check.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (over_current_count == $past(over_current_count)
      || over_current_count == $past(over_current_count) + CUR_CNT_W'(1)
      || over_current_count == $past(over_current_count) - CUR_CNT_W'(1)))
    else $error("over-current counter jumped");

  // A result is only loaded when the output register is free.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(result.end_cause)))
    else $error("pending result overwritten");

endmodule
